/* rtl/sbot_pkg.sv */
// ----------------------------------------------------------------------------
// sbot_pkg: shared types and constants
// constants, stage enables and axis tables for the segment/box overlap test
// ----------------------------------------------------------------------------
`default_nettype none

package sbot_pkg;

	localparam int unsigned COORD_BITS_DEF = 24;
	localparam int unsigned EPS_W          = 8;
	localparam logic [EPS_W-1:0] EPS_RESET = 8'd1;
	localparam int unsigned NUM_AXES       = 3;
	localparam int unsigned NUM_FIELDS     = 12;

	// cross axis k = d x unit(k) uses components a and b
	localparam int unsigned AX_A [NUM_AXES] = '{1, 2, 0};
	localparam int unsigned AX_B [NUM_AXES] = '{2, 0, 1};

	// load enables of the five pipeline registers
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

`default_nettype wire

/* rtl/sbot_prep.sv */
// ----------------------------------------------------------------------------
// sbot_prep: setup and box axis tests
// forms doubled extents, direction and midpoint offset, then tests box axes
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_prep #(
	parameter int unsigned COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
	input  wire                                    clk,
	input  wire sbot_pkg::stage_en_t               en,
	input  wire [2:0][COORD_BITS-1:0]              seg_start,
	input  wire [2:0][COORD_BITS-1:0]              seg_end,
	input  wire [2:0][COORD_BITS-1:0]              box_min,
	input  wire [2:0][COORD_BITS-1:0]              box_max,
	input  wire [sbot_pkg::EPS_W-1:0]              eps,
	output logic signed [COORD_BITS+1:0]           m_s2 [3],
	output logic signed [COORD_BITS:0]             d_s2 [3],
	output logic signed [COORD_BITS:0]             e_s2 [3],
	output logic [COORD_BITS:0]                    ade_s2 [3],
	output logic                                   box_hit_s2
);
	import sbot_pkg::*;

	localparam int unsigned N = COORD_BITS;

	logic signed [N+1:0] m_c [3];
	logic signed [N:0]   d_c [3];
	logic signed [N:0]   e_c [3];
	logic signed [N+1:0] m_s1 [3];
	logic signed [N:0]   d_s1 [3];
	logic signed [N:0]   e_s1 [3];

	logic [N+1:0]        am [3];
	logic [N:0]          ad [3];
	logic signed [N+2:0] reach [3];
	logic [2:0]          sep;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_c[i] = $signed({box_max[i][N-1], box_max[i]})
				- $signed({box_min[i][N-1], box_min[i]});
			d_c[i] = $signed({seg_end[i][N-1], seg_end[i]})
				- $signed({seg_start[i][N-1], seg_start[i]});
			m_c[i] = $signed({{2{seg_start[i][N-1]}}, seg_start[i]})
				+ $signed({{2{seg_end[i][N-1]}}, seg_end[i]})
				- $signed({{2{box_min[i][N-1]}}, box_min[i]})
				- $signed({{2{box_max[i][N-1]}}, box_max[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			m_s1 <= m_c;
			d_s1 <= d_c;
			e_s1 <= e_c;
		end
	end

	// box axes: |m| > e + |d| separates
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			am[i]    = m_s1[i][N+1] ? (N+2)'(0) - m_s1[i] : m_s1[i];
			ad[i]    = d_s1[i][N] ? (N+1)'(0) - d_s1[i] : d_s1[i];
			reach[i] = $signed({{2{e_s1[i][N]}}, e_s1[i]}) + $signed({2'b00, ad[i]});
			sep[i]   = $signed({1'b0, am[i]}) > reach[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			m_s2       <= m_s1;
			d_s2       <= d_s1;
			e_s2       <= e_s1;
			box_hit_s2 <= ~|sep;
			for (int i = 0; i < 3; i++) begin
				ade_s2[i] <= ad[i] + {{(N+1-EPS_W){1'b0}}, eps};
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/sbot_cross.sv */
// ----------------------------------------------------------------------------
// sbot_cross: cross product axis tests
// multiplies, sums and compares for the three axes d x unit axis
// ----------------------------------------------------------------------------
`default_nettype none

module sbot_cross #(
	parameter int unsigned COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
	input  wire                                    clk,
	input  wire sbot_pkg::stage_en_t               en,
	input  wire signed [COORD_BITS+1:0]            m_s2 [3],
	input  wire signed [COORD_BITS:0]              d_s2 [3],
	input  wire signed [COORD_BITS:0]              e_s2 [3],
	input  wire [COORD_BITS:0]                     ade_s2 [3],
	input  wire                                    box_hit_s2,
	output logic                                   hit_s5
);
	import sbot_pkg::*;

	localparam int unsigned N   = COORD_BITS;
	localparam int unsigned P_W = 2 * N + 3;
	localparam int unsigned S_W = P_W + 1;

	logic signed [P_W-1:0] pmd_s3 [3];   // m_a * d_b
	logic signed [P_W-1:0] pdm_s3 [3];   // m_b * d_a
	logic signed [P_W-1:0] pea_s3 [3];   // e_a * (|d_b| + eps)
	logic signed [P_W-1:0] peb_s3 [3];   // e_b * (|d_a| + eps)
	logic                  box_hit_s3;

	logic signed [S_W-1:0] dif_s4 [3];
	logic signed [S_W-1:0] rhs_s4 [3];
	logic                  box_hit_s4;

	logic [S_W-1:0]        adif [3];
	logic [2:0]            sep;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			box_hit_s3 <= box_hit_s2;
			for (int k = 0; k < 3; k++) begin
				pmd_s3[k] <= P_W'(m_s2[AX_A[k]] * d_s2[AX_B[k]]);
				pdm_s3[k] <= P_W'(m_s2[AX_B[k]] * d_s2[AX_A[k]]);
				pea_s3[k] <= P_W'(e_s2[AX_A[k]] * $signed({1'b0, ade_s2[AX_B[k]]}));
				peb_s3[k] <= P_W'(e_s2[AX_B[k]] * $signed({1'b0, ade_s2[AX_A[k]]}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			box_hit_s4 <= box_hit_s3;
			for (int k = 0; k < 3; k++) begin
				dif_s4[k] <= $signed({pmd_s3[k][P_W-1], pmd_s3[k]})
					- $signed({pdm_s3[k][P_W-1], pdm_s3[k]});
				rhs_s4[k] <= $signed({pea_s3[k][P_W-1], pea_s3[k]})
					+ $signed({peb_s3[k][P_W-1], peb_s3[k]});
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			adif[k] = dif_s4[k][S_W-1] ? S_W'(0) - dif_s4[k] : dif_s4[k];
			sep[k]  = $signed({1'b0, adif[k]}) > $signed({rhs_s4[k][S_W-1], rhs_s4[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			hit_s5 <= box_hit_s4 & ~|sep;
		end
	end

endmodule

`default_nettype wire

/* rtl/segment_box_overlap_test_unit.sv */
// ----------------------------------------------------------------------------
// segment_box_overlap_test_unit: segment versus box overlap test
// separating axis test of a 3d segment against an axis-aligned box
// ----------------------------------------------------------------------------
// usage
//   s_tdata carries one segment and one box per transfer; m_tdata returns the
//   overlap flag for that pair, in order, one result per input transfer
//   parallel_epsilon is set through cfg_wr_en / cfg_wr_data; the user must
//   write it only while no transfer is in flight, as the block does not
//   enforce this; it widens |d| in the cross axis tests (coordinate lsbs)
//   m_tvalid is the valid bit of the last (compare) register stage
//   throughput: one pair per cycle while the receiver does not stall; five
//   register stages (setup, box axes, products, sums, compare) each pass one item per clock
//   each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up while the receiver stalls; with
//   all five stages full and m_tready low, s_tready drops and nothing moves
//   arst_n clears all valid bits and sets parallel_epsilon to 1
// ----------------------------------------------------------------------------
`default_nettype none

module segment_box_overlap_test_unit #(
	parameter int unsigned COORD_BITS = sbot_pkg::COORD_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// configuration write, no read-back
	input  wire                         cfg_wr_en,
	input  wire [sbot_pkg::EPS_W-1:0]   cfg_wr_data,      // parallel_epsilon
	// input stream
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
	// each COORD_BITS wide from bit 0 up, zero padding to whole bytes
	input  wire [((sbot_pkg::NUM_FIELDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// output stream
	output logic                        m_tvalid,
	input  wire                         m_tready,
	output logic [7:0]                  m_tdata            // overlap_hit, then zeros
);
	import sbot_pkg::*;

	localparam int unsigned N = COORD_BITS;

	logic [EPS_W-1:0]     eps_q;

	// one valid bit per pipeline register
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	stage_en_t            en;

	logic [2:0][N-1:0]    seg_start, seg_end, box_min, box_max;

	logic signed [N+1:0]  m_s2 [3];
	logic signed [N:0]    d_s2 [3];
	logic signed [N:0]    e_s2 [3];
	logic [N:0]           ade_s2 [3];
	logic                 box_hit_s2;
	logic                 hit_s5;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// a stage loads when it is empty or its content moves on this cycle
	always_comb begin
		en.s5 = !v_s5 || m_tready;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign s_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// unpack the twelve coordinates, x/y/z within each point
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			seg_start[i] = s_tdata[i*N +: N];
			seg_end[i]   = s_tdata[(3+i)*N +: N];
			box_min[i]   = s_tdata[(6+i)*N +: N];
			box_max[i]   = s_tdata[(9+i)*N +: N];
		end
	end

	// setup (s1) and box axis tests plus epsilon add (s2)
	sbot_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk        (clk),
		.en         (en),
		.seg_start  (seg_start),
		.seg_end    (seg_end),
		.box_min    (box_min),
		.box_max    (box_max),
		.eps        (eps_q),
		.m_s2       (m_s2),
		.d_s2       (d_s2),
		.e_s2       (e_s2),
		.ade_s2     (ade_s2),
		.box_hit_s2 (box_hit_s2)
	);

	// products (s3), differences and sums (s4), compare and result (s5)
	sbot_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk        (clk),
		.en         (en),
		.m_s2       (m_s2),
		.d_s2       (d_s2),
		.e_s2       (e_s2),
		.ade_s2     (ade_s2),
		.box_hit_s2 (box_hit_s2),
		.hit_s5     (hit_s5)
	);

	// s5 is the output register
	assign m_tvalid = v_s5;
	assign m_tdata  = {7'b0, hit_s5};

endmodule

`default_nettype wire

/* test/tb_segment_box_overlap_test_unit.sv */
// ----------------------------------------------------------------------------
// tb_segment_box_overlap_test_unit: self-checking bench for the overlap test
// drives segment/box pairs into the input stream with random gaps, predicts
// the overlap flag of every accepted pair and checks each output transfer
// against the oldest prediction, while the receiver stalls at random
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_box_overlap_test_unit;

	import sbot_pkg::*;

	localparam int W        = COORD_BITS_DEF;
	localparam int DATA_W   = ((NUM_FIELDS*W+7)/8)*8;
	localparam int MAXC     = (1 << (W-1)) - 1;
	localparam int MINC     = -(1 << (W-1));
	localparam int LATENCY  = 5;
	localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
	localparam int HOLD_CYCLES = 150;    // long receiver hold-off

	typedef logic signed [W-1:0] coord_t;

	// one segment/box pair, axes indexed x=0, y=1, z=2
	typedef struct packed {
		coord_t [2:0] seg_start;
		coord_t [2:0] seg_end;
		coord_t [2:0] box_min;
		coord_t [2:0] box_max;
	} seg_box_t;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [EPS_W-1:0]  cfg_wr_data = '0;
	logic              s_tvalid    = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata     = '0;
	logic              m_tvalid;
	logic              m_tready    = 1'b0;
	logic [7:0]        m_tdata;

	// bench-side copy of the epsilon register
	logic [EPS_W-1:0] eps_shadow = EPS_RESET;

	// overlap flags still to come, oldest first
	bit hit_expected_q[$];

	int errors       = 0;
	int results_seen = 0;
	int stall_count  = 0;

	// knobs shared with the receiver process and the sender idling
	int rx_hold_left = 0;
	bit rx_steady    = 1'b0;
	bit tx_steady    = 1'b0;

	segment_box_overlap_test_unit #(.COORD_BITS(W)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// overlap predictor: doubled-scale separating axis test in 64 bits
	// ------------------------------------------------------------------
	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit predict_overlap(seg_box_t p, logic [EPS_W-1:0] eps);
		longint ext[3], dir[3], mid[3], adir[3];
		longint cross_lhs, cross_rhs;
		int a, b;
		bit hit;
		hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			ext[k]  = longint'($signed(p.box_max[k])) - longint'($signed(p.box_min[k]));
			dir[k]  = longint'($signed(p.seg_end[k])) - longint'($signed(p.seg_start[k]));
			mid[k]  = longint'($signed(p.seg_start[k])) + longint'($signed(p.seg_end[k]))
			        - longint'($signed(p.box_min[k])) - longint'($signed(p.box_max[k]));
			adir[k] = mag(dir[k]);
			// box face axes
			if (mag(mid[k]) > ext[k] + adir[k])
				hit = 1'b0;
		end
		if (hit) begin
			for (int k = 0; k < 3; k++)
				adir[k] = adir[k] + longint'(eps);
			// edge axes d x unit(k), built from components a and b
			for (int k = 0; k < 3; k++) begin
				a = AX_A[k];
				b = AX_B[k];
				cross_lhs = mag(mid[a]*dir[b] - mid[b]*dir[a]);
				cross_rhs = ext[a]*adir[b] + ext[b]*adir[a];
				if (cross_lhs > cross_rhs)
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

	function automatic logic [DATA_W-1:0] pack_pair(seg_box_t p);
		logic [DATA_W-1:0] data;
		data = '0;
		for (int k = 0; k < 3; k++) begin
			data[k*W +: W]     = p.seg_start[k];
			data[(3+k)*W +: W] = p.seg_end[k];
			data[(6+k)*W +: W] = p.box_min[k];
			data[(9+k)*W +: W] = p.box_max[k];
		end
		return data;
	endfunction

	// ------------------------------------------------------------------
	// pair generators
	// ------------------------------------------------------------------
	function automatic seg_box_t pair_of(int sx, int sy, int sz, int ex, int ey, int ez,
	                                     int nx, int ny, int nz, int xx, int xy, int xz);
		seg_box_t p;
		p.seg_start = {coord_t'(sz), coord_t'(sy), coord_t'(sx)};
		p.seg_end   = {coord_t'(ez), coord_t'(ey), coord_t'(ex)};
		p.box_min   = {coord_t'(nz), coord_t'(ny), coord_t'(nx)};
		p.box_max   = {coord_t'(xz), coord_t'(xy), coord_t'(xx)};
		return p;
	endfunction

	function automatic int signed_rand(int range);
		return int'($urandom_range(0, 2*range)) - range;
	endfunction

	// box and segment of similar size around one center, so hits and near
	// misses both show up; sh sets the scale, some axes are made parallel
	function automatic seg_box_t near_pair(int sh, int parallel_pct);
		seg_box_t p;
		int c, h;
		coord_t tmp;
		for (int k = 0; k < 3; k++) begin
			c = signed_rand(1 << 22);
			h = int'($urandom_range(0, 1 << sh));
			p.box_min[k]   = coord_t'(c - h);
			p.box_max[k]   = coord_t'(c + h);
			p.seg_start[k] = coord_t'(c + signed_rand(3 << sh));
			if (int'($urandom_range(0, 99)) < parallel_pct)
				p.seg_end[k] = p.seg_start[k];
			else
				p.seg_end[k] = coord_t'(c + signed_rand(3 << sh));
		end
		// rare inverted box on one axis
		if ($urandom_range(0, 19) == 0) begin
			c = $urandom_range(0, 2);
			tmp = p.box_min[c];
			p.box_min[c] = p.box_max[c];
			p.box_max[c] = tmp;
		end
		return p;
	endfunction

	function automatic seg_box_t noise_pair();
		seg_box_t p;
		for (int k = 0; k < 3; k++) begin
			p.seg_start[k] = coord_t'($urandom);
			p.seg_end[k]   = coord_t'($urandom);
			p.box_min[k]   = coord_t'($urandom);
			p.box_max[k]   = coord_t'($urandom);
		end
		return p;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------
	// offer one pair and hold it until the block takes it; the prediction
	// is queued at the accepting edge with the epsilon in force
	task automatic send_pair(seg_box_t p);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= pack_pair(p);
		do @(posedge clk); while (!s_tready);
		hit_expected_q.push_back(predict_overlap(p, eps_shadow));
	endtask

	task automatic tx_idle();
		int n;
		n = tx_steady ? 0 : pick_gap();
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n-1) @(negedge clk);
		end
	endtask

	task automatic send_and_idle(seg_box_t p);
		send_pair(p);
		tx_idle();
	endtask

	// stop offering and wait until every queued result has been checked
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (hit_expected_q.size() == 0);
	endtask

	// only written with the pipeline empty
	task automatic write_epsilon(logic [EPS_W-1:0] value);
		drain_results();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		eps_shadow   = value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// receiver side: random ready with runs, plus an on-demand hold-off
	// ------------------------------------------------------------------
	initial begin
		int run_left;
		bit run_ready;
		run_left  = 0;
		run_ready = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else if (rx_steady) begin
				m_tready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					if ($urandom_range(0, 3) != 0) begin
						run_ready = 1'b1;
						run_left  = $urandom_range(1, 20);
					end else begin
						run_ready = 1'b0;
						run_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						                                        : $urandom_range(1, 3);
					end
				end
				run_left--;
				m_tready <= run_ready;
			end
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what);
		$display("mismatch at result %0d: %s", results_seen, what);
		errors++;
	endtask

	always @(posedge clk) begin
		bit want;
		if (arst_n && m_tvalid && m_tready) begin
			if (hit_expected_q.size() == 0) begin
				report_mismatch("result with no pending pair");
			end else begin
				want = hit_expected_q.pop_front();
				if (m_tdata[0] !== want)
					report_mismatch($sformatf("overlap_hit got %b want %b", m_tdata[0], want));
			end
			results_seen++;
		end
	end

	// watchdog: a run of cycles with no transfer on either side ends the run
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// field extremes and the named special cases, run at the reset epsilon
	task automatic test_directed_cases();
		seg_box_t p;
		rx_steady = 1'b1;
		tx_steady = 1'b1;
		// point in a point-sized box at zero, at the top and at the bottom of range
		send_and_idle(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_and_idle(pair_of(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
		                      MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
		send_and_idle(pair_of(MINC, MINC, MINC, MINC, MINC, MINC,
		                      MINC, MINC, MINC, MINC, MINC, MINC));
		// full-range box crossed corner to corner, both directions
		send_and_idle(pair_of(MINC, MINC, MINC, MAXC, MAXC, MAXC,
		                      MINC, MINC, MINC, MAXC, MAXC, MAXC));
		send_and_idle(pair_of(MAXC, MAXC, MAXC, MINC, MINC, MINC,
		                      MINC, MINC, MINC, MAXC, MAXC, MAXC));
		// full-length segment against point boxes at the far corners
		send_and_idle(pair_of(MAXC, MINC, MAXC, MINC, MAXC, MINC,
		                      MINC, MINC, MINC, MINC, MINC, MINC));
		send_and_idle(pair_of(MINC, MINC, MINC, MAXC, MAXC, MAXC,
		                      MAXC, MINC, MAXC, MAXC, MINC, MAXC));
		// degenerate segment: point inside, point outside
		send_and_idle(pair_of(100, 200, 300, 100, 200, 300, 0, 0, 0, 1000, 1000, 1000));
		send_and_idle(pair_of(2000, 0, 0, 2000, 0, 0, 0, 0, 0, 1000, 1000, 1000));
		// point exactly on a face
		send_and_idle(pair_of(1000, 500, 0, 1000, 500, 0, 0, 0, 0, 1000, 1000, 1000));
		// straight through along x, and beside the box on y
		send_and_idle(pair_of(-5000, 500, 500, 5000, 500, 500, 0, 0, 0, 1000, 1000, 1000));
		send_and_idle(pair_of(-5000, 1500, 500, 5000, 1500, 500,
		                      0, 0, 0, 1000, 1000, 1000));
		// diagonal that clears the corner: only an edge axis separates
		send_and_idle(pair_of(-384, 256, 128, 256, -384, 128, 0, 0, 0, 256, 256, 256));
		// same diagonal just touching the corner
		send_and_idle(pair_of(-384, 384, 128, 384, -384, 128, 0, 0, 0, 256, 256, 256));
		// diagonal one lsb past the corner on each edge axis pair
		send_and_idle(pair_of(128, -1, -1, -1, 128, -1, 0, 0, 0, 0, 0, 0));
		send_and_idle(pair_of(-1, 128, -1, -1, -1, 128, 0, 0, 0, 0, 0, 0));
		send_and_idle(pair_of(-1, -1, 128, 128, -1, -1, 0, 0, 0, 0, 0, 0));
		// inverted box: point in the middle, then a long segment across it
		send_and_idle(pair_of(500, 500, 500, 500, 500, 500, 1000, 0, 0, 0, 1000, 1000));
		send_and_idle(pair_of(-3000, 500, 500, 4000, 500, 500,
		                      1000, 0, 0, 0, 1000, 1000));
		// alternating bit patterns in every field
		send_and_idle(pair_of('h555555, 'h555555, 'h555555, 'haaaaaa, 'haaaaaa, 'haaaaaa,
		                      'haaaaaa, 'haaaaaa, 'haaaaaa, 'h555555, 'h555555, 'h555555));
		send_and_idle(pair_of('haaaaaa, 'h555555, 'haaaaaa, 'h555555, 'haaaaaa, 'h555555,
		                      'h555555, 'haaaaaa, 'h555555, 'haaaaaa, 'h555555, 'haaaaaa));
		// segment parallel to z running along a box edge
		send_and_idle(pair_of(1000, 1000, -500, 1000, 1000, 1500,
		                      0, 0, 0, 1000, 1000, 1000));
		send_and_idle(pair_of(1001, 1001, -500, 1001, 1001, 1500,
		                      0, 0, 0, 1000, 1000, 1000));
		rx_steady = 1'b0;
		tx_steady = 1'b0;
	endtask

	// epsilon at zero, at its maximum and back at one, on small near misses
	// where the edge-axis margin is a few lsbs
	task automatic test_epsilon_extremes();
		logic [EPS_W-1:0] settings [3];
		settings = '{8'd0, 8'd255, 8'd1};
		foreach (settings[i]) begin
			write_epsilon(settings[i]);
			repeat (50)
				send_and_idle(near_pair($urandom_range(1, 6), 30));
		end
	endtask

	// receiver holds off while the sender keeps offering back to back, so
	// the pipeline fills and the input stalls
	task automatic test_receiver_hold();
		drain_results();
		rx_hold_left = HOLD_CYCLES;
		tx_steady    = 1'b1;
		repeat (40)
			send_and_idle(near_pair($urandom_range(4, 16), 10));
		tx_steady    = 1'b0;
	endtask

	// sender pauses with results still in flight, then carries on
	task automatic test_drain_pause();
		repeat (12)
			send_and_idle(near_pair($urandom_range(2, 12), 10));
		drain_results();
		repeat (12)
			send_and_idle(near_pair($urandom_range(2, 12), 10));
	endtask

	// bulk random: mostly near pairs of all scales, some parallel-heavy,
	// some full-range noise; epsilon changes between blocks and the
	// idling switches between random and none
	task automatic test_random_mix();
		int r;
		for (int blk = 0; blk < 4; blk++) begin
			write_epsilon(EPS_W'($urandom_range(0, 255)));
			rx_steady = (blk == 2);
			tx_steady = (blk == 2);
			repeat (150) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					send_and_idle(near_pair($urandom_range(0, 20), 10));
				else if (r < 90)
					send_and_idle(near_pair($urandom_range(0, 4), 50));
				else
					send_and_idle(noise_pair());
			end
		end
		rx_steady = 1'b0;
		tx_steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_epsilon_extremes();
		test_receiver_hold();
		test_drain_pause();
		test_random_mix();

		// wait out the pipeline; a lost result trips the watchdog
		drain_results();
		repeat (LATENCY*4) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

/* segment_box_overlap_test_unit.f */
rtl/sbot_pkg.sv
rtl/sbot_prep.sv
rtl/sbot_cross.sv
rtl/segment_box_overlap_test_unit.sv
test/tb_segment_box_overlap_test_unit.sv
